/* hdl/dbd_pkg.sv */
package dbd_pkg;

  // request field widths
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;

  // day number of any 14-bit year fits in 23 bits
  localparam int DNUM_W  = 23;
  localparam int COUNT_W = 22;
  localparam int DOY_W   = 9;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;

  localparam int unsigned DEFAULT_MAX_YEAR = 9999;
  localparam int MAXY_W = 17;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // x / 100 == (x * 5243) >> 19, exact for x below 43690
  localparam int PROD_W      = 28;
  localparam int RECIP_100   = 5243;
  localparam int RECIP_SHIFT = 19;
  localparam int QUOT_W      = 8;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } pipe_en_t;

  // days in the whole months before month m of a common year
  function automatic logic [DOY_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] r;
    unique case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

/* hdl/days_between_dates.sv */
// Absolute day distance between two Gregorian dates, one request per clock unless the output
// stalls. The pipeline has a stage of reciprocal multiplies for the century and 400-year
// counts, a stage for the leap test and partial sums, a stage for the day number and a stage
// for the absolute difference that is also the output register. Every stage holds only
// while the stage after it is full and stalled, so bubbles are squeezed out and a stalled
// output still lets new requests in until the pipeline is full. Years above MAX_YEAR are
// clamped to it, months outside 1..12 are clamped, days are added to the start of the month
// unchecked, and the count saturates at the top of its 22-bit field.
module days_between_dates #(
  parameter int unsigned MAX_YEAR = dbd_pkg::DEFAULT_MAX_YEAR
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // year_a[13:0], month_a[17:14], day_a[22:18], year_b[36:23], month_b[40:37],
  // day_b[45:41], zero fill
  input  logic [dbd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // day_count[21:0], zero fill
  output logic [dbd_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import dbd_pkg::*;

  logic [YEAR_W-1:0]  year_a;
  logic [MONTH_W-1:0] month_a;
  logic [DAY_W-1:0]   day_a;
  logic [YEAR_W-1:0]  year_b;
  logic [MONTH_W-1:0] month_b;
  logic [DAY_W-1:0]   day_b;

  assign year_a  = s_axis_tdata[13:0];
  assign month_a = s_axis_tdata[17:14];
  assign day_a   = s_axis_tdata[22:18];
  assign year_b  = s_axis_tdata[36:23];
  assign month_b = s_axis_tdata[40:37];
  assign day_b   = s_axis_tdata[45:41];

  logic     v1;
  logic     v2;
  logic     v3;
  logic     v4;
  logic     en4;
  pipe_en_t en;

  // a stage may load when empty or when its successor moves
  always_comb begin
    en4    = !v4 || m_axis_tready;
    en.en3 = !v3 || en4;
    en.en2 = !v2 || en.en3;
    en.en1 = !v1 || en.en2;
  end

  assign s_axis_tready = en.en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en.en1) v1 <= s_axis_tvalid;
      if (en.en2) v2 <= v1;
      if (en.en3) v3 <= v2;
      if (en4)    v4 <= v3;
    end
  end

  logic [DNUM_W-1:0]  num_a;
  logic [DNUM_W-1:0]  num_b;
  logic [COUNT_W-1:0] day_count;

  dbd_day_num #(.MAX_YEAR(MAX_YEAR)) u_num_a (
    .clk     (clk),
    .en      (en),
    .year    (year_a),
    .month   (month_a),
    .day     (day_a),
    .day_num (num_a)
  );

  dbd_day_num #(.MAX_YEAR(MAX_YEAR)) u_num_b (
    .clk     (clk),
    .en      (en),
    .year    (year_b),
    .month   (month_b),
    .day     (day_b),
    .day_num (num_b)
  );

  dbd_diff u_diff (
    .clk       (clk),
    .en        (en4),
    .num_a     (num_a),
    .num_b     (num_b),
    .day_count (day_count)
  );

  assign m_axis_tvalid = v4;
  assign m_axis_tdata  = {(OUT_DATA_W-COUNT_W)'(0), day_count};

  // an empty output stage means the whole chain can move
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output stage empty");

  // a full stalled pipeline must refuse new requests
  a_full_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && v3 && v4 && !m_axis_tready) |-> !s_axis_tready)
    else $error("request accepted into a full stalled pipeline");

  // a stage that holds a request and cannot move keeps it
  a_stage3_holds: assert property (@(posedge clk) disable iff (rst)
    (v3 && v4 && !m_axis_tready) |=> v3)
    else $error("request lost in stage three during stall");

endmodule

/* hdl/dbd_day_num.sv */
module dbd_day_num #(
  parameter int unsigned MAX_YEAR = dbd_pkg::DEFAULT_MAX_YEAR
) (
  input  logic                         clk,
  input  dbd_pkg::pipe_en_t            en,
  input  logic [dbd_pkg::YEAR_W-1:0]   year,
  input  logic [dbd_pkg::MONTH_W-1:0]  month,
  input  logic [dbd_pkg::DAY_W-1:0]    day,
  output logic [dbd_pkg::DNUM_W-1:0]   day_num
);
  import dbd_pkg::*;

  localparam logic [MAXY_W-1:0] MAX_Y = MAXY_W'(MAX_YEAR);

  // stage 1: clamp, reciprocal multiplies
  logic [YEAR_W-1:0]  y_sat;
  logic [MONTH_W-1:0] m_sat;
  logic [YEAR_W:0]    t100;
  logic [YEAR_W:0]    t400;
  logic [YEAR_W:0]    t4;

  logic [DNUM_W-1:0]  s1_y365;
  logic [PROD_W-1:0]  s1_p100c;
  logic [PROD_W-1:0]  s1_p100f;
  logic [PROD_W-1:0]  s1_p400c;
  logic [YEAR_W-2:0]  s1_c4;
  logic [1:0]         s1_ylo;
  logic [MONTH_W-1:0] s1_m;
  logic [DAY_W-1:0]   s1_d;

  always_comb begin
    if (MAXY_W'(year) > MAX_Y) begin
      y_sat = MAX_Y[YEAR_W-1:0];
    end else begin
      y_sat = year;
    end
    priority if (month < MONTH_JAN) begin
      m_sat = MONTH_JAN;
    end else if (month > MONTH_DEC) begin
      m_sat = MONTH_DEC;
    end else begin
      m_sat = month;
    end
    t4   = (YEAR_W+1)'(y_sat) + (YEAR_W+1)'(3);
    t100 = (YEAR_W+1)'(y_sat) + (YEAR_W+1)'(99);
    t400 = (YEAR_W+1)'(y_sat) + (YEAR_W+1)'(399);
  end

  always_ff @(posedge clk) begin
    if (en.en1) begin
      s1_y365  <= DNUM_W'(y_sat) * DNUM_W'(365);
      s1_p100c <= PROD_W'(t100) * PROD_W'(RECIP_100);
      s1_p100f <= PROD_W'(y_sat) * PROD_W'(RECIP_100);
      // ceil(y/400) = ceil((y+3)/4 ... ) taken as ((y+399)>>2)/100
      s1_p400c <= PROD_W'(t400[YEAR_W:2]) * PROD_W'(RECIP_100);
      s1_c4    <= t4[YEAR_W:2];
      s1_ylo   <= y_sat[1:0];
      s1_m     <= m_sat;
      s1_d     <= day;
    end
  end

  // stage 2: quotients, leap test, day of year
  logic [QUOT_W-1:0] c100;
  logic [QUOT_W-1:0] f100;
  logic [QUOT_W-1:0] c400;
  logic              leap;
  logic [DOY_W-1:0]  doy;

  logic [DNUM_W-1:0] s2_a;
  logic [DOY_W-1:0]  s2_b;

  always_comb begin
    c100 = s1_p100c[RECIP_SHIFT +: QUOT_W];
    f100 = s1_p100f[RECIP_SHIFT +: QUOT_W];
    c400 = s1_p400c[RECIP_SHIFT +: QUOT_W];
    // ceil equals floor only for whole centuries
    leap = (s1_ylo == 2'b00) && ((c100 != f100) || (f100[1:0] == 2'b00));
    doy  = days_before_month(s1_m) + DOY_W'(leap && (s1_m > MONTH_FEB)) + DOY_W'(s1_d);
  end

  always_ff @(posedge clk) begin
    if (en.en2) begin
      s2_a <= s1_y365 + DNUM_W'(s1_c4) - DNUM_W'(c100);
      s2_b <= doy + DOY_W'(c400);
    end
  end

  // stage 3: final sum
  always_ff @(posedge clk) begin
    if (en.en3) begin
      day_num <= s2_a + DNUM_W'(s2_b);
    end
  end

endmodule

/* hdl/dbd_diff.sv */
module dbd_diff (
  input  logic                         clk,
  input  logic                         en,
  input  logic [dbd_pkg::DNUM_W-1:0]   num_a,
  input  logic [dbd_pkg::DNUM_W-1:0]   num_b,
  output logic [dbd_pkg::COUNT_W-1:0]  day_count
);
  import dbd_pkg::*;

  logic [DNUM_W-1:0]  diff;
  logic [COUNT_W-1:0] count_sat;

  always_comb begin
    if (num_a >= num_b) begin
      diff = num_a - num_b;
    end else begin
      diff = num_b - num_a;
    end
    if (diff > DNUM_W'(COUNT_MAX)) begin
      count_sat = COUNT_MAX;
    end else begin
      count_sat = diff[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      day_count <= count_sat;
    end
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import dbd_pkg::*;

  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 12;
  localparam int unsigned YEAR_CLAMP    = 9999;
  localparam int unsigned DAY_COUNT_SAT = 4194303;

  // first member sits in the top bits, so year_a lands at bit 0
  typedef struct packed {
    logic [DAY_W-1:0]   day_b;
    logic [MONTH_W-1:0] month_b;
    logic [YEAR_W-1:0]  year_b;
    logic [DAY_W-1:0]   day_a;
    logic [MONTH_W-1:0] month_a;
    logic [YEAR_W-1:0]  year_a;
  } date_pair_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  logic [COUNT_W-1:0] expected_counts[$];
  int unsigned month_start [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
  int error_count     = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int hold_request    = 0;
  int hold_left       = 0;
  int idle_cycles     = 0;

  days_between_dates dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit gregorian_leap(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_length(int unsigned y, int unsigned m);
    case (m)
      2:            return gregorian_leap(y) ? 29 : 28;
      4, 6, 9, 11:  return 30;
      default:      return 31;
    endcase
  endfunction

  // days since the start of year 0, with the block's clamping of year and month
  function automatic int unsigned day_ordinal(logic [YEAR_W-1:0] yr, logic [MONTH_W-1:0] mo,
                                              logic [DAY_W-1:0] dy);
    int unsigned y;
    int unsigned m;
    int unsigned n;
    y = 32'(yr);
    m = 32'(mo);
    if (y > YEAR_CLAMP) y = YEAR_CLAMP;
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    n += month_start[m-1];
    if (m > 2 && gregorian_leap(y)) n += 1;
    n += 32'(dy);
    return n;
  endfunction

  function automatic logic [COUNT_W-1:0] predict_day_count(date_pair_t p);
    int unsigned na;
    int unsigned nb;
    int unsigned span;
    na = day_ordinal(p.year_a, p.month_a, p.day_a);
    nb = day_ordinal(p.year_b, p.month_b, p.day_b);
    span = (na >= nb) ? na - nb : nb - na;
    if (span > DAY_COUNT_SAT) span = DAY_COUNT_SAT;
    return COUNT_W'(span);
  endfunction

  function automatic date_pair_t random_date_pair();
    date_pair_t p;
    date_pair_t q;
    int unsigned pick;
    logic [31:0] bits;
    pick = $urandom_range(99);
    p.year_a  = YEAR_W'($urandom_range(YEAR_CLAMP));
    p.month_a = MONTH_W'($urandom_range(12, 1));
    p.day_a   = DAY_W'($urandom_range(month_length(p.year_a, p.month_a), 1));
    // nearby dates exercise month and year boundaries more than spread-out ones
    if (pick < 20)
      p.year_b = p.year_a;
    else if (pick < 35 && p.year_a < YEAR_CLAMP)
      p.year_b = p.year_a + 1'b1;
    else
      p.year_b = YEAR_W'($urandom_range(YEAR_CLAMP));
    p.month_b = MONTH_W'($urandom_range(12, 1));
    p.day_b   = DAY_W'($urandom_range(month_length(p.year_b, p.month_b), 1));
    // noise: out-of-range fields take raw random bits
    if (pick >= 85) begin
      bits = $urandom;
      if (bits[0]) p.year_a  = YEAR_W'($urandom);
      if (bits[1]) p.month_a = MONTH_W'($urandom);
      if (bits[2]) p.day_a   = DAY_W'($urandom);
      if (bits[3]) p.year_b  = YEAR_W'($urandom);
      if (bits[4]) p.month_b = MONTH_W'($urandom);
      if (bits[5]) p.day_b   = DAY_W'($urandom);
    end
    if ($urandom_range(1) == 1) begin
      q = p;
      p.year_a  = q.year_b;
      p.month_a = q.month_b;
      p.day_a   = q.day_b;
      p.year_b  = q.year_a;
      p.month_b = q.month_a;
      p.day_b   = q.day_a;
    end
    return p;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] mismatch: %s, got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // called right after a rising edge; returns right after the edge that took the request
  task automatic send_request(input date_pair_t p);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DATA_W - $bits(date_pair_t)){1'b0}}, p};
    do @(posedge clk); while (!s_axis_tready);
    expected_counts.push_back(predict_day_count(p));
  endtask

  task automatic send_dates(input int ya, input int ma, input int da,
                            input int yb, input int mb, input int db);
    date_pair_t p;
    p.year_a  = YEAR_W'(ya);
    p.month_a = MONTH_W'(ma);
    p.day_a   = DAY_W'(da);
    p.year_b  = YEAR_W'(yb);
    p.month_b = MONTH_W'(mb);
    p.day_b   = DAY_W'(db);
    send_request(p);
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_counts.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    sender_idle_pct = 8;
    recv_stall_pct  = 8;
    send_dates(2024, 5, 17, 2024, 5, 17);
    send_dates(0, 1, 1, 9999, 12, 31);
    send_dates(9999, 12, 31, 0, 1, 1);
    // leap rules: 400 rule, century, plain, common, year zero
    send_dates(2000, 2, 28, 2000, 3, 1);
    send_dates(1900, 2, 28, 1900, 3, 1);
    send_dates(2004, 2, 28, 2004, 3, 1);
    send_dates(2001, 2, 28, 2001, 3, 1);
    send_dates(0, 2, 28, 0, 3, 1);
    send_dates(1999, 12, 31, 2000, 1, 1);
    send_dates(400, 12, 31, 401, 1, 1);
    send_dates(1600, 3, 1, 1700, 3, 1);
    // years past the clamp
    send_dates(16383, 6, 15, 9999, 6, 15);
    send_dates(10000, 1, 1, 9999, 1, 1);
    // month clamping
    send_dates(2023, 0, 10, 2023, 1, 10);
    send_dates(2023, 13, 5, 2023, 12, 5);
    send_dates(2023, 15, 31, 2023, 12, 31);
    // unchecked days roll into neighbor months
    send_dates(2023, 3, 0, 2023, 2, 28);
    send_dates(2023, 2, 31, 2023, 3, 3);
    send_dates(2024, 2, 30, 2024, 3, 1);
    send_dates(2100, 2, 29, 2100, 3, 1);
    send_dates(16383, 15, 31, 0, 0, 0);
    send_dates(0, 0, 0, 0, 0, 0);
    send_dates(9999, 12, 31, 9999, 12, 30);
    send_dates(5461, 10, 21, 10922, 5, 10);
    wait_for_results();
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    repeat (count) send_request(random_date_pair());
    wait_for_results();
  endtask

  // output held off long enough for the pipeline to fill and back up into the input
  task automatic test_output_holdoff();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_request    = 400;
    repeat (24) send_request(random_date_pair());
    wait_for_results();
  endtask

  task automatic test_sender_pause();
    sender_idle_pct = 8;
    recv_stall_pct  = 8;
    repeat (10) send_request(random_date_pair());
    wait_for_results();
    repeat (10) send_request(random_date_pair());
    wait_for_results();
  endtask

  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    logic [COUNT_W-1:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_counts.size() == 0) begin
        report_mismatch("day_count with no request pending", m_axis_tdata[COUNT_W-1:0], 0);
      end else begin
        want = expected_counts.pop_front();
        if (m_axis_tdata[COUNT_W-1:0] !== want)
          report_mismatch("day_count", m_axis_tdata[COUNT_W-1:0], want);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("days_between_dates verification failed");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_phase(0, 0, 400);
    test_random_phase(79, 0, 400);
    test_random_phase(0, 79, 400);
    test_random_phase(8, 8, 400);
    test_output_holdoff();
    test_sender_pause();
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_counts.size() == 0)
      $display("days_between_dates verification clean");
    else
      $display("days_between_dates verification failed");
    $finish;
  end

endmodule
